// File: design/dmtt_pkg.sv
// Shared types and constants for the deadline timer slot table.
// Used by dmtt_eval and multi_slot_deadline_timer_table; no dependencies.
`default_nettype none

package dmtt_pkg;

   localparam int SLOT_COUNT   = 8;
   localparam int HANDLER_BITS = 16;

   localparam int NOW_W     = 64;
   localparam int DUR_W     = 32;
   localparam int HANDLER_W = 16;
   localparam int TAG_W     = 32;
   localparam int DUE_W     = 32;

   // Handler bits kept in a slot: the field is 16 bits wide.
   localparam int HANDLER_KEEP = (HANDLER_BITS < HANDLER_W) ? HANDLER_BITS : HANDLER_W;

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);

   localparam logic [DUE_W-1:0] NEXT_NONE = 32'hFFFF_FFFF;
   localparam logic [DUE_W-1:0] NEXT_MAX  = 32'hFFFF_FFFE;

   localparam int REQ_FIELD_W = NOW_W + DUR_W + HANDLER_W + TAG_W + 1;
   localparam int REQ_DATA_W  = ((REQ_FIELD_W + 7) / 8) * 8;
   localparam int RSP_FIELD_W = 2 + 1 + HANDLER_W + TAG_W + 1 + DUE_W;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_DATA_W - RSP_FIELD_W;

   typedef enum logic [1:0] {
      CMD_REGISTER = 2'd0,
      CMD_STOP     = 2'd1,
      CMD_QUERY    = 2'd2,
      CMD_EXPIRE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2
   } status_type;

   typedef struct packed {
      logic                    low_power;
      logic [HANDLER_KEEP-1:0] handler;
      logic [TAG_W-1:0]        tag;
      logic [NOW_W-1:0]        deadline;
   } entry_type;

   // Sequencer to evaluation unit.
   typedef struct packed {
      logic             start;
      logic             step;
      logic             finish;
      cmd_type          cmd;
      logic [IDX_W-1:0] idx;
   } eval_ctl_type;

   // Per-slot verdict for the slot under evaluation.
   typedef struct packed {
      logic clear;
      logic fire;
   } eval_hit_type;

   // Summary of the table after the step.
   typedef struct packed {
      logic             lp_ok;
      logic [DUE_W-1:0] next_due;
      logic             found;
      logic             has_free;
      logic [IDX_W-1:0] free_idx;
   } eval_sum_type;

endpackage

`default_nettype wire

// File: design/dmtt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module dmtt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: design/dmtt_eval.sv
// Shared slot evaluation unit: key match, deadline compares and the running
// summary (low power, nearest deadline, first free slot). Uses dmtt_pkg.
`default_nettype none

module dmtt_eval (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire dmtt_pkg::eval_ctl_type              ctl,
   input  wire logic [dmtt_pkg::NOW_W-1:0]          now,
   input  wire logic [dmtt_pkg::HANDLER_KEEP-1:0]   key_handler,
   input  wire logic [dmtt_pkg::TAG_W-1:0]          key_tag,
   input  wire logic                                slot_used,
   input  wire dmtt_pkg::entry_type                 entry,
   output dmtt_pkg::eval_hit_type                   hit,
   output dmtt_pkg::eval_sum_type                   sum
);

   logic                            lp_ok_ff, lp_ok_in;
   logic                            any_ff, any_in;
   logic                            found_ff, found_in;
   logic                            has_free_ff, has_free_in;
   logic [dmtt_pkg::IDX_W-1:0]      free_idx_ff, free_idx_in;
   logic [dmtt_pkg::NOW_W-1:0]      best_ff, best_in;
   logic [dmtt_pkg::DUE_W-1:0]      due_ff, due_in;

   logic                            match, late, due, post, pending, better;
   logic                            clear, fire;
   logic [dmtt_pkg::NOW_W-1:0]      diff;

   assign match = slot_used && (entry.tag == key_tag) && (entry.handler == key_handler);
   assign late  = entry.deadline < now;
   assign due   = slot_used && (late || (entry.deadline == now));

   // A stop frees only the first matching slot in index order.
   assign clear = ((ctl.cmd == dmtt_pkg::CMD_STOP) && match && !found_ff)
                  || ((ctl.cmd == dmtt_pkg::CMD_EXPIRE) && due);
   assign fire  = (ctl.cmd == dmtt_pkg::CMD_EXPIRE) && due && (entry.handler != '0);

   // The summary looks at the slot as it stands after the step.
   assign post    = slot_used && !clear;
   assign pending = post && !late;
   assign better  = !any_ff || (entry.deadline < best_ff);
   assign diff    = best_ff - now;

   always_comb begin
      lp_ok_in    = lp_ok_ff;
      any_in      = any_ff;
      found_in    = found_ff;
      has_free_in = has_free_ff;
      free_idx_in = free_idx_ff;
      best_in     = best_ff;
      due_in      = due_ff;
      if (ctl.start) begin
         lp_ok_in    = 1'b1;
         any_in      = 1'b0;
         found_in    = 1'b0;
         has_free_in = 1'b0;
      end else if (ctl.step) begin
         if (match) begin
            found_in = 1'b1;
         end
         if (post && !entry.low_power) begin
            lp_ok_in = 1'b0;
         end
         if (pending) begin
            any_in = 1'b1;
            if (better) begin
               best_in = entry.deadline;
            end
         end
         if (!post && !has_free_ff) begin
            has_free_in = 1'b1;
            free_idx_in = ctl.idx;
         end
      end else if (ctl.finish) begin
         if (!any_ff) begin
            due_in = dmtt_pkg::NEXT_NONE;
         end else if ((diff[63:32] != '0) || (diff[31:0] == dmtt_pkg::NEXT_NONE)) begin
            due_in = dmtt_pkg::NEXT_MAX;
         end else begin
            due_in = diff[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lp_ok_ff    <= 1'b1;
         any_ff      <= 1'b0;
         found_ff    <= 1'b0;
         has_free_ff <= 1'b1;
         free_idx_ff <= '0;
         due_ff      <= dmtt_pkg::NEXT_NONE;
      end else begin
         lp_ok_ff    <= lp_ok_in;
         any_ff      <= any_in;
         found_ff    <= found_in;
         has_free_ff <= has_free_in;
         free_idx_ff <= free_idx_in;
         due_ff      <= due_in;
      end
      best_ff <= best_in;
   end

   assign hit.clear    = clear;
   assign hit.fire     = fire;
   assign sum.lp_ok    = lp_ok_ff;
   assign sum.next_due = due_ff;
   assign sum.found    = found_ff;
   assign sum.has_free = has_free_ff;
   assign sum.free_idx = free_idx_ff;

endmodule

`default_nettype wire

// File: design/multi_slot_deadline_timer_table.sv
// Top level of the deadline timer slot table: sequencer, in-use bits and
// result register. Uses dmtt_pkg, dmtt_ram and dmtt_eval.
//
// Usage: each request word on req_ carries a command in req_tuser and the
// current time, duration, handler, tag and low-power flag in req_tdata.
// A register command writes a free slot, if any, in the cycle the word is accepted.
// The block then scans every slot through one shared evaluation unit,
// one slot a cycle with the slot RAM read one slot ahead, and in a final
// state turns the nearest deadline into a millisecond distance.
// Register, stop and query give one response word; an expire gives one word
// per freed slot with a nonzero handler (or a single empty word), the final
// one flagged by rsp_tlast. rsp_tuser is set on words that report a fired slot.
// Sequence: the accept, the scan state, a final state that finishes the
// summary, then a state for a single response; an expire that fires walks
// the slots instead, seeking past each skipped slot and passing through a
// fire state for each fired one, and goes idle after the last fired slot.
// req_tready is high only while the block waits for a command; a finished
// response sits in the output register, so the next command is taken while
// it waits. If the receiver stalls, the sequencer holds before loading the
// next response word. Reset empties the table at once; no clearing pass.
`default_nettype none

module multi_slot_deadline_timer_table (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [63:0] now_ms, [95:64] duration_ms, [111:96] handler_id,
   // [143:112] tag_value, [144] allow_low_power, [151:145] zero
   input  wire logic [dmtt_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [1:0] command
   input  wire logic [1:0]                          req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [1:0] status, [2] is_running, [18:3] fired_handler, [50:19] fired_tag,
   // [51] low_power_ok, [83:52] next_due_ms, [87:84] zero
   output logic [dmtt_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   // [0] fired_valid
   output logic                                     rsp_tuser,
   output logic                                     rsp_tlast
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINAL,
      ST_SEEK,
      ST_FIRE,
      ST_ONE
   } state_type;

   state_type                           state_ff, state_in;
   dmtt_pkg::cmd_type                   cmd_ff, cmd_in;
   logic                                full_ff, full_in;
   logic [dmtt_pkg::NOW_W-1:0]          now_ff, now_in;
   logic [dmtt_pkg::HANDLER_KEEP-1:0]   handler_ff, handler_in;
   logic [dmtt_pkg::TAG_W-1:0]          tag_ff, tag_in;
   logic [dmtt_pkg::CNT_W-1:0]          cnt_ff, cnt_in;
   logic [dmtt_pkg::CNT_W-1:0]          fire_cnt_ff, fire_cnt_in;
   logic [dmtt_pkg::SLOT_COUNT-1:0]     in_use_ff, in_use_in;
   logic [dmtt_pkg::SLOT_COUNT-1:0]     fire_ff, fire_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   dmtt_pkg::status_type                rsp_status_ff, rsp_status_in;
   logic                                rsp_running_ff, rsp_running_in;
   logic                                rsp_fired_ff, rsp_fired_in;
   logic [dmtt_pkg::HANDLER_W-1:0]      rsp_handler_ff, rsp_handler_in;
   logic [dmtt_pkg::TAG_W-1:0]          rsp_tag_ff, rsp_tag_in;
   logic                                rsp_lp_ff, rsp_lp_in;
   logic [dmtt_pkg::DUE_W-1:0]          rsp_due_ff, rsp_due_in;
   logic                                rsp_last_ff, rsp_last_in;

   dmtt_pkg::cmd_type                   req_cmd;
   logic [dmtt_pkg::NOW_W-1:0]          req_now;
   logic [dmtt_pkg::DUR_W-1:0]          req_dur;
   logic [dmtt_pkg::HANDLER_W-1:0]      req_handler;
   logic [dmtt_pkg::TAG_W-1:0]          req_tag;
   logic                                req_lp;

   logic                                accept, rsp_space, wr_en, last_fire;
   logic [dmtt_pkg::IDX_W-1:0]          pidx, cidx;
   dmtt_pkg::entry_type                 wr_entry, rd_entry;
   logic [$bits(dmtt_pkg::entry_type)-1:0] rd_word;
   dmtt_pkg::eval_ctl_type              ctl;
   dmtt_pkg::eval_hit_type              hit;
   dmtt_pkg::eval_sum_type              sum;

   assign req_cmd     = dmtt_pkg::cmd_type'(req_tuser);
   assign req_now     = req_tdata[63:0];
   assign req_dur     = req_tdata[95:64];
   assign req_handler = req_tdata[111:96];
   assign req_tag     = req_tdata[143:112];
   assign req_lp      = req_tdata[144];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_space  = !rsp_valid_ff || rsp_tready;

   // The new slot is written at accept so that the scan already sees it.
   assign wr_en             = accept && (req_cmd == dmtt_pkg::CMD_REGISTER) && sum.has_free;
   assign wr_entry.low_power = req_lp;
   assign wr_entry.handler   = req_handler[dmtt_pkg::HANDLER_KEEP-1:0];
   assign wr_entry.tag       = req_tag;
   assign wr_entry.deadline  = req_now + dmtt_pkg::NOW_W'(req_dur);

   // The read address runs one slot ahead of the slot being evaluated.
   assign cidx = cnt_ff[dmtt_pkg::IDX_W-1:0];
   assign pidx = dmtt_pkg::IDX_W'(cnt_ff - dmtt_pkg::CNT_W'(1));

   dmtt_ram #(
      .WIDTH ($bits(dmtt_pkg::entry_type)),
      .DEPTH (dmtt_pkg::SLOT_COUNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (sum.free_idx),
      .wr_data (wr_entry),
      .rd_addr (cidx),
      .rd_data (rd_word)
   );

   assign rd_entry = rd_word;

   assign ctl.start  = accept;
   assign ctl.step   = (state_ff == ST_SCAN) && (cnt_ff != '0);
   assign ctl.finish = (state_ff == ST_FINAL);
   assign ctl.cmd    = cmd_ff;
   assign ctl.idx    = pidx;

   dmtt_eval u_eval (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .now         (now_ff),
      .key_handler (handler_ff),
      .key_tag     (tag_ff),
      .slot_used   (in_use_ff[pidx]),
      .entry       (rd_entry),
      .hit         (hit),
      .sum         (sum)
   );

   assign last_fire = (fire_cnt_ff == dmtt_pkg::CNT_W'(1));

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      full_in        = full_ff;
      now_in         = now_ff;
      handler_in     = handler_ff;
      tag_in         = tag_ff;
      cnt_in         = cnt_ff;
      fire_cnt_in    = fire_cnt_ff;
      in_use_in      = in_use_ff;
      fire_in        = fire_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_running_in = rsp_running_ff;
      rsp_fired_in   = rsp_fired_ff;
      rsp_handler_in = rsp_handler_ff;
      rsp_tag_in     = rsp_tag_ff;
      rsp_lp_in      = rsp_lp_ff;
      rsp_due_in     = rsp_due_ff;
      rsp_last_in    = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in      = req_cmd;
               full_in     = !sum.has_free;
               now_in      = req_now;
               handler_in  = req_handler[dmtt_pkg::HANDLER_KEEP-1:0];
               tag_in      = req_tag;
               cnt_in      = '0;
               fire_cnt_in = '0;
               fire_in     = '0;
               if (wr_en) begin
                  in_use_in[sum.free_idx] = 1'b1;
               end
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (ctl.step && hit.clear) begin
               in_use_in[pidx] = 1'b0;
            end
            if (ctl.step && hit.fire) begin
               fire_in[pidx] = 1'b1;
               fire_cnt_in   = fire_cnt_ff + dmtt_pkg::CNT_W'(1);
            end
            if (cnt_ff == dmtt_pkg::CNT_W'(dmtt_pkg::SLOT_COUNT)) begin
               state_in = ST_FINAL;
            end else begin
               cnt_in = cnt_ff + dmtt_pkg::CNT_W'(1);
            end
         end
         ST_FINAL: begin
            cnt_in = '0;
            if ((cmd_ff == dmtt_pkg::CMD_EXPIRE) && (fire_cnt_ff != '0)) begin
               state_in = ST_SEEK;
            end else begin
               state_in = ST_ONE;
            end
         end
         ST_SEEK: begin
            // The RAM word for this slot is valid in the following cycle.
            if (fire_ff[cidx]) begin
               state_in = ST_FIRE;
            end else begin
               cnt_in = cnt_ff + dmtt_pkg::CNT_W'(1);
            end
         end
         ST_FIRE: begin
            if (rsp_space) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = dmtt_pkg::STATUS_OK;
               rsp_running_in = 1'b0;
               rsp_fired_in   = 1'b1;
               rsp_handler_in = dmtt_pkg::HANDLER_W'(rd_entry.handler);
               rsp_tag_in     = rd_entry.tag;
               rsp_lp_in      = sum.lp_ok;
               rsp_due_in     = sum.next_due;
               rsp_last_in    = last_fire;
               fire_cnt_in    = fire_cnt_ff - dmtt_pkg::CNT_W'(1);
               cnt_in         = cnt_ff + dmtt_pkg::CNT_W'(1);
               state_in       = last_fire ? ST_IDLE : ST_SEEK;
            end
         end
         ST_ONE: begin
            if (rsp_space) begin
               rsp_valid_in = 1'b1;
               case (cmd_ff)
                  dmtt_pkg::CMD_REGISTER: begin
                     rsp_status_in = full_ff ? dmtt_pkg::STATUS_FULL : dmtt_pkg::STATUS_OK;
                  end
                  dmtt_pkg::CMD_STOP: begin
                     rsp_status_in = sum.found ? dmtt_pkg::STATUS_OK
                                               : dmtt_pkg::STATUS_NOT_FOUND;
                  end
                  default: begin
                     rsp_status_in = dmtt_pkg::STATUS_OK;
                  end
               endcase
               rsp_running_in = (cmd_ff == dmtt_pkg::CMD_QUERY) && sum.found;
               rsp_fired_in   = 1'b0;
               rsp_handler_in = '0;
               rsp_tag_in     = '0;
               rsp_lp_in      = sum.lp_ok;
               rsp_due_in     = sum.next_due;
               rsp_last_in    = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         fire_cnt_ff  <= '0;
         in_use_ff    <= '0;
         fire_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         fire_cnt_ff  <= fire_cnt_in;
         in_use_ff    <= in_use_in;
         fire_ff      <= fire_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff         <= cmd_in;
      full_ff        <= full_in;
      now_ff         <= now_in;
      handler_ff     <= handler_in;
      tag_ff         <= tag_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_running_ff <= rsp_running_in;
      rsp_fired_ff   <= rsp_fired_in;
      rsp_handler_ff <= rsp_handler_in;
      rsp_tag_ff     <= rsp_tag_in;
      rsp_lp_ff      <= rsp_lp_in;
      rsp_due_ff     <= rsp_due_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{dmtt_pkg::RSP_PAD_W{1'b0}}, rsp_due_ff, rsp_lp_ff, rsp_tag_ff,
                        rsp_handler_ff, rsp_running_ff, rsp_status_ff};
   assign rsp_tuser  = rsp_fired_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_fired_has_handler: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_fired_ff |-> rsp_handler_ff != '0)
      else $error("fired response word carries a zero handler");

   a_single_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_fired_ff |-> rsp_last_ff)
      else $error("non-fired response word is not the last of its command");

   a_register_marks_slot: assert property (@(posedge clock) disable iff (reset)
      accept && (req_cmd == dmtt_pkg::CMD_REGISTER) && sum.has_free
      |=> in_use_ff[$past(sum.free_idx)])
      else $error("registered slot is not marked in use");

   a_idle_no_pending_fire: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (fire_cnt_ff == '0))
      else $error("fired slots left unreported when the sequencer went idle");

endmodule

`default_nettype wire
